// ----- src/rhr_pkg.sv -----
// Shared constants, types and codes of the rainbow hue-to-RGB converter.
`timescale 1ns / 1ps
`default_nettype none

package rhr_pkg;

  // Fraction bits of the colour arithmetic
  localparam int unsigned FRAC_BITS = 16;

  localparam int unsigned COLOUR_W    = 8;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned HASH_W      = 24;
  localparam int unsigned SUM_W       = 29;
  localparam int unsigned QUOT_W      = 21;
  localparam int unsigned HUE_W       = 9;
  localparam int unsigned H120_W      = 7;
  localparam int unsigned TRI_W       = 6;
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned NUM_STAGES  = 8;

  // Configuration port
  localparam int unsigned REG_W       = 16;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;
  localparam logic [REG_W-1:0] SATURATION_RST = 16'd45875;
  localparam logic [REG_W-1:0] BRIGHTNESS_RST = 16'd45875;

  typedef enum logic {
    REG_SATURATION = 1'b0,
    REG_BRIGHTNESS = 1'b1
  } reg_idx_e;

  // Divide by ten: exact for every 32-bit time stamp
  localparam int unsigned DIV10_SHIFT = 35;
  localparam logic [TIME_W-1:0] DIV10_MULT = 32'hCCCC_CCCD;

  // Divide by 360: exact for sums below 2^29
  localparam int unsigned   DIV360_SHIFT  = 39;
  localparam int unsigned   DIV360_W      = 31;
  localparam longint unsigned DIV360_MULT_L = ((64'd1 << DIV360_SHIFT) + 64'd359) / 64'd360;
  localparam logic [DIV360_W-1:0] DIV360_MULT = DIV360_MULT_L[DIV360_W-1:0];

  // Divide by 60: exact for chroma times triangle below 60 * 2^FRAC_BITS
  localparam int unsigned   DIV60_SHIFT  = FRAC_BITS + 12;
  localparam int unsigned   DIV60_W      = FRAC_BITS + 7;
  localparam longint unsigned DIV60_MULT_L = ((64'd1 << DIV60_SHIFT) + 64'd59) / 64'd60;
  localparam logic [DIV60_W-1:0] DIV60_MULT = DIV60_MULT_L[DIV60_W-1:0];

  localparam int unsigned XPROD_W = FRAC_BITS + TRI_W;

  // Hue boundaries
  localparam logic [HUE_W-1:0] HUE_60  = 9'd60;
  localparam logic [HUE_W-1:0] HUE_120 = 9'd120;
  localparam logic [HUE_W-1:0] HUE_180 = 9'd180;
  localparam logic [HUE_W-1:0] HUE_240 = 9'd240;
  localparam logic [HUE_W-1:0] HUE_300 = 9'd300;

  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } sector_e;

  // Colour terms derived from the saturation and brightness registers
  typedef struct packed {
    logic [FRAC_BITS-1:0] chroma;
    logic [FRAC_BITS-1:0] offset;
  } cfg_t;

endpackage

`default_nettype wire

// ----- src/rhr_cfg.sv -----
// APB register file for saturation and brightness, with derived chroma and offset.
`timescale 1ns / 1ps
`default_nettype none

module rhr_cfg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [rhr_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [rhr_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [rhr_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                 pready,
  output rhr_pkg::cfg_t                        cfg_o
);
  import rhr_pkg::*;

  logic [REG_W-1:0]          sat_q, bri_q;
  logic                      wr_en;
  reg_idx_e                  idx;
  logic [2*REG_W-1:0]        sv_prod;
  logic [FRAC_BITS+REG_W-1:0] v_ext;
  logic [FRAC_BITS-1:0]      chroma_d, chroma_q, value_d, value_q;
  cfg_t                      cfg_d, cfg_q;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= SATURATION_RST;
      bri_q <= BRIGHTNESS_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_SATURATION: sat_q <= pwdata[REG_W-1:0];
        REG_BRIGHTNESS: bri_q <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SATURATION: prdata = APB_DATA_W'(sat_q);
      REG_BRIGHTNESS: prdata = APB_DATA_W'(bri_q);
      default:        prdata = '0;
    endcase
  end

  // Chroma is S*V scaled to the fraction width; value is V rescaled
  assign sv_prod  = sat_q * bri_q;
  assign chroma_d = sv_prod[2*REG_W-1 -: FRAC_BITS];
  assign v_ext    = {bri_q, {FRAC_BITS{1'b0}}};
  assign value_d  = v_ext[FRAC_BITS+REG_W-1:REG_W];

  assign cfg_d.chroma = chroma_q;
  assign cfg_d.offset = value_q - chroma_q;

  always_ff @(posedge clk_i) begin
    chroma_q <= chroma_d;
    value_q  <= value_d;
    cfg_q    <= cfg_d;
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- src/rainbow_hue_to_rgb_top.sv -----
// Top level of the rainbow hue-to-RGB converter: eight-stage colour pipeline.
`timescale 1ns / 1ps
`default_nettype none

//  Channel     | Dir | Handshake                        | Contents
//  ------------+-----+----------------------------------+--------------------------------
//  s_axis      | in  | s_axis_tvalid / s_axis_tready    | source colour and time stamp
//  m_axis      | out | m_axis_tvalid / m_axis_tready    | rotated RGB colour
//  apb         | in  | psel, penable, pwrite, pready    | saturation (0x0), brightness (0x4)
//
//  One request enters per clock unless back-pressure has filled the pipeline; results leave
//  in request order. The two reciprocal multipliers (divide by ten and by 360) and the
//  chroma-times-triangle multiply are each followed by their own register stage.
//  Reset clears the stage valid bits and loads both registers with about 0.7.
//  A stalled stage holds its contents; an empty stage keeps taking from the one before it,
//  so bubbles close up and nothing is lost or repeated. Register writes reach the
//  pipeline through the chroma and value registers, then the cfg register.

module rainbow_hue_to_rgb_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // s_axis_tdata: in_red [7:0], in_green [15:8], in_blue [23:16], time_ms [55:24]
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [rhr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // m_axis_tdata: out_red [7:0], out_green [15:8], out_blue [23:16]
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic      [rhr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [rhr_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [rhr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [rhr_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                  pready
);
  import rhr_pkg::*;

  localparam int unsigned F = FRAC_BITS;

  cfg_t cfg;

  rhr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // ---------------------------------------------------------------------------
  // Flow control: a stage takes new contents when empty or when its successor moves
  // ---------------------------------------------------------------------------
  logic [NUM_STAGES-1:0] vld_q;
  logic [NUM_STAGES:0]   adv;

  always_comb begin
    adv[NUM_STAGES] = m_axis_tready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready = adv[0];
  assign m_axis_tvalid = vld_q[NUM_STAGES-1];

  // ---------------------------------------------------------------------------
  // Stage 1: colour hash and time stamp times the reciprocal of ten
  // ---------------------------------------------------------------------------
  logic [COLOUR_W-1:0]   in_red, in_green, in_blue;
  logic [TIME_W-1:0]     time_ms;
  logic [15:0]           hash_hi;
  logic [HASH_W-1:0]     hash_d, hash1_q;
  logic [2*TIME_W-1:0]   prod10_d, prod10_q;

  assign in_red   = s_axis_tdata[7:0];
  assign in_green = s_axis_tdata[15:8];
  assign in_blue  = s_axis_tdata[23:16];
  assign time_ms  = s_axis_tdata[55:24];

  // (r*255 + g)*255 + b, each times 255 done as shift and subtract
  assign hash_hi  = {in_red, 8'd0} - {8'd0, in_red} + {8'd0, in_green};
  assign hash_d   = {hash_hi, 8'd0} - {8'd0, hash_hi} + {16'd0, in_blue};
  assign prod10_d = time_ms * DIV10_MULT;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      hash1_q  <= hash_d;
      prod10_q <= prod10_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: hue sum = time/10 + hash (stays below 2^29)
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0] sum_d, sum2_q;

  assign sum_d = prod10_q[DIV10_SHIFT +: SUM_W] + SUM_W'(hash1_q);

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      sum2_q <= sum_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: quotient of the sum by 360 through the reciprocal
  // ---------------------------------------------------------------------------
  logic [SUM_W+DIV360_W-1:0] prod360;
  logic [QUOT_W-1:0]         quot3_q;
  logic [SUM_W-1:0]          sum3_q;

  assign prod360 = sum2_q * DIV360_MULT;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      quot3_q <= prod360[DIV360_SHIFT +: QUOT_W];
      sum3_q  <= sum2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: hue = sum - 360*quotient
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0] q360, hue_full;
  logic [HUE_W-1:0] hue4_q;

  assign q360     = SUM_W'({quot3_q, 8'd0}) + SUM_W'({quot3_q, 6'd0})
                  + SUM_W'({quot3_q, 5'd0}) + SUM_W'({quot3_q, 3'd0});
  assign hue_full = sum3_q - q360;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      hue4_q <= hue_full[HUE_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: sector and triangle distance 60 - |(hue mod 120) - 60|
  // ---------------------------------------------------------------------------
  sector_e           sec_d, sec5_q, sec6_q;
  logic [HUE_W-1:0]  h120_full;
  logic [H120_W-1:0] h120, tri_full;
  logic [TRI_W-1:0]  tri5_q;

  always_comb begin
    if (hue4_q < HUE_60)       sec_d = SEC_RED;
    else if (hue4_q < HUE_120) sec_d = SEC_YELLOW;
    else if (hue4_q < HUE_180) sec_d = SEC_GREEN;
    else if (hue4_q < HUE_240) sec_d = SEC_CYAN;
    else if (hue4_q < HUE_300) sec_d = SEC_BLUE;
    else                       sec_d = SEC_MAGENTA;

    if (hue4_q < HUE_120)      h120_full = hue4_q;
    else if (hue4_q < HUE_240) h120_full = hue4_q - HUE_120;
    else                       h120_full = hue4_q - HUE_240;
    h120 = h120_full[H120_W-1:0];

    if (h120 >= HUE_60[H120_W-1:0]) tri_full = HUE_120[H120_W-1:0] - h120;
    else                             tri_full = h120;
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      sec5_q <= sec_d;
      tri5_q <= tri_full[TRI_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: chroma times triangle
  // ---------------------------------------------------------------------------
  logic [XPROD_W-1:0] xprod6_q;

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      xprod6_q <= cfg.chroma * tri5_q;
      sec6_q   <= sec5_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: second component = product / 60, then route per sector
  // ---------------------------------------------------------------------------
  logic [XPROD_W+DIV60_W-1:0] prod60;
  logic [F-1:0]               xq, chroma;
  logic [F-1:0]               red_d, green_d, blue_d;
  logic [F-1:0]               red7_q, green7_q, blue7_q;

  assign prod60 = xprod6_q * DIV60_MULT;
  assign xq     = prod60[DIV60_SHIFT +: F];
  assign chroma = cfg.chroma;

  always_comb begin
    case (sec6_q)
      SEC_RED:     begin red_d = chroma; green_d = xq;     blue_d = '0;     end
      SEC_YELLOW:  begin red_d = xq;     green_d = chroma; blue_d = '0;     end
      SEC_GREEN:   begin red_d = '0;     green_d = chroma; blue_d = xq;     end
      SEC_CYAN:    begin red_d = '0;     green_d = xq;     blue_d = chroma; end
      SEC_BLUE:    begin red_d = xq;     green_d = '0;     blue_d = chroma; end
      default:     begin red_d = chroma; green_d = '0;     blue_d = xq;     end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      red7_q   <= red_d;
      green7_q <= green_d;
      blue7_q  <= blue_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 8: channel = ((component + offset) * 255) >> F, held for the consumer
  // ---------------------------------------------------------------------------
  logic [F:0]          red_sum, green_sum, blue_sum;
  logic [F+8:0]        red_sc, green_sc, blue_sc;
  logic [COLOUR_W-1:0] out_red_q, out_green_q, out_blue_q;

  assign red_sum   = {1'b0, red7_q}   + {1'b0, cfg.offset};
  assign green_sum = {1'b0, green7_q} + {1'b0, cfg.offset};
  assign blue_sum  = {1'b0, blue7_q}  + {1'b0, cfg.offset};
  assign red_sc    = {red_sum, 8'd0}   - {8'd0, red_sum};
  assign green_sc  = {green_sum, 8'd0} - {8'd0, green_sum};
  assign blue_sc   = {blue_sum, 8'd0}  - {8'd0, blue_sum};

  always_ff @(posedge clk_i) begin
    if (adv[7]) begin
      out_red_q   <= red_sc[F +: COLOUR_W];
      out_green_q <= green_sc[F +: COLOUR_W];
      out_blue_q  <= blue_sc[F +: COLOUR_W];
    end
  end

  assign m_axis_tdata = {out_blue_q, out_green_q, out_red_q};

endmodule

`default_nettype wire

// ----- tb/sv/rainbow_hue_to_rgb_top_test.sv -----
// Self-checking testbench of the rainbow hue-to-RGB converter top level.
`timescale 1ns / 1ps

module rainbow_hue_to_rgb_top_test;
  import rhr_pkg::*;

  // Source colour and time stamp as packed on s_axis_tdata (red in the lowest byte)
  typedef struct packed {
    logic [TIME_W-1:0]   time_ms;
    logic [COLOUR_W-1:0] blue;
    logic [COLOUR_W-1:0] green;
    logic [COLOUR_W-1:0] red;
  } src_colour_t;

  // Rotated colour as packed on m_axis_tdata
  typedef struct packed {
    logic [COLOUR_W-1:0] blue;
    logic [COLOUR_W-1:0] green;
    logic [COLOUR_W-1:0] red;
  } rgb_t;

  // One row of the opening stimulus: register setting, request, and an optional
  // hand-worked result for the cases that can be read off directly
  typedef struct packed {
    logic [REG_W-1:0]    sat;
    logic [REG_W-1:0]    bri;
    logic [COLOUR_W-1:0] red;
    logic [COLOUR_W-1:0] green;
    logic [COLOUR_W-1:0] blue;
    logic [TIME_W-1:0]   time_ms;
    bit                  known;
    rgb_t                want;
  } opening_row_t;

  localparam int unsigned HALF_PERIOD  = 4;
  localparam int unsigned RESET_CYCLES = 5;
  localparam int unsigned IDLE_PCT     = 24;
  localparam int unsigned HOLD_CYCLES  = 64;
  localparam int unsigned RAND_PHASES  = 8;
  localparam int unsigned PHASE_ITEMS  = 100;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned OPEN_ROWS    = 23;

  logic                   clk_i  = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   psel    = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr   = '0;
  logic [APB_DATA_W-1:0]  pwdata  = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  // Local copy of the two colour registers
  logic [REG_W-1:0] sat_q = SATURATION_RST;
  logic [REG_W-1:0] bri_q = BRIGHTNESS_RST;

  rgb_t        colour_due [$];
  int unsigned err_cnt   = 0;
  int unsigned cycle_cnt = 0;
  bit          calm      = 1'b0;
  bit          hold_go   = 1'b0;
  int unsigned hold_left = 0;
  rgb_t        got_rgb;
  rgb_t        want_rgb;

  rainbow_hue_to_rgb_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Opening stimulus. Hand-worked results: with both registers at reset chroma is 32112
  // and the offset 13763, giving 178 for the largest and 53 for the smallest channel;
  // zero saturation gives a grey at the brightness, full saturation and brightness give
  // pure primaries at 254, zero brightness gives black. Sector corners (hue multiple of
  // 60) make the middle component either zero or equal to the chroma.
  opening_row_t opening_rows [OPEN_ROWS] = '{
    '{16'd45875, 16'd45875, 8'd0,   8'd0,   8'd0,   32'd0,        1'b1, '{8'd53, 8'd53, 8'd178}},
    '{16'd45875, 16'd45875, 8'd255, 8'd255, 8'd255, 32'hFFFFFFFF, 1'b0, '0},
    '{16'd45875, 16'd45875, 8'd0,   8'd0,   8'd0,   32'd600,      1'b1, '{8'd53, 8'd178, 8'd178}},
    '{16'd45875, 16'd45875, 8'd0,   8'd0,   8'd0,   32'd1200,     1'b1, '{8'd53, 8'd178, 8'd53}},
    '{16'd45875, 16'd45875, 8'd0,   8'd0,   8'd0,   32'd1800,     1'b1, '{8'd178, 8'd178, 8'd53}},
    '{16'd45875, 16'd45875, 8'd0,   8'd0,   8'd0,   32'd2400,     1'b1, '{8'd178, 8'd53, 8'd53}},
    '{16'd45875, 16'd45875, 8'd0,   8'd0,   8'd0,   32'd3000,     1'b1, '{8'd178, 8'd53, 8'd178}},
    '{16'd45875, 16'd45875, 8'd0,   8'd0,   8'd0,   32'd3590,     1'b0, '0},
    '{16'd45875, 16'd45875, 8'd0,   8'd0,   8'd0,   32'd3600,     1'b1, '{8'd53, 8'd53, 8'd178}},
    '{16'd45875, 16'd45875, 8'd0,   8'd0,   8'd0,   32'd9,        1'b1, '{8'd53, 8'd53, 8'd178}},
    '{16'd45875, 16'd45875, 8'd0,   8'd0,   8'd0,   32'd10,       1'b0, '0},
    '{16'd45875, 16'd45875, 8'd1,   8'd0,   8'd0,   32'd0,        1'b0, '0},
    '{16'd45875, 16'd45875, 8'd0,   8'd1,   8'd0,   32'd0,        1'b0, '0},
    '{16'd45875, 16'd45875, 8'd0,   8'd0,   8'd1,   32'd0,        1'b0, '0},
    '{16'd45875, 16'd45875, 8'd128, 8'd64,  8'd32,  32'd12345,    1'b0, '0},
    '{16'd0,     16'd65535, 8'd17,  8'd99,  8'd200, 32'd777,      1'b1, '{8'd254, 8'd254, 8'd254}},
    '{16'd0,     16'd65535, 8'd255, 8'd0,   8'd255, 32'd0,        1'b1, '{8'd254, 8'd254, 8'd254}},
    '{16'd65535, 16'd65535, 8'd0,   8'd0,   8'd0,   32'd0,        1'b1, '{8'd0, 8'd0, 8'd254}},
    '{16'd65535, 16'd65535, 8'd0,   8'd0,   8'd0,   32'd1200,     1'b1, '{8'd0, 8'd254, 8'd0}},
    '{16'd65535, 16'd65535, 8'd0,   8'd0,   8'd0,   32'd2400,     1'b1, '{8'd254, 8'd0, 8'd0}},
    '{16'd65535, 16'd65535, 8'd0,   8'd0,   8'd0,   32'd600,      1'b1, '{8'd0, 8'd254, 8'd254}},
    '{16'd65535, 16'd0,     8'd200, 8'd100, 8'd50,  32'd99999,    1'b1, '{8'd0, 8'd0, 8'd0}},
    '{16'd0,     16'd0,     8'd255, 8'd255, 8'd255, 32'hFFFFFFFF, 1'b1, '{8'd0, 8'd0, 8'd0}}
  };

  // Hash the colour, add the time in tens of milliseconds, reduce to a hue and
  // convert it with the six-sector formula in FRAC_BITS fixed point
  function automatic rgb_t rotate_hue(src_colour_t src, logic [REG_W-1:0] sat,
                                      logic [REG_W-1:0] bri);
    logic [31:0] hash;
    logic [31:0] hue_sum;
    logic [31:0] hue;
    logic [31:0] h120;
    logic [31:0] tri_dist;
    logic [63:0] chroma;
    logic [63:0] val;
    logic [63:0] offs;
    logic [63:0] mid;
    logic [63:0] comp [3];
    sector_e     sector;
    rgb_t        res;
    hash     = (32'(src.red) * 32'd255 + 32'(src.green)) * 32'd255 + 32'(src.blue);
    hue_sum  = src.time_ms / 32'd10 + hash;
    hue      = hue_sum % 32'd360;
    chroma   = (64'(sat) * 64'(bri)) >> (32 - FRAC_BITS);
    val      = (64'(bri) << FRAC_BITS) >> REG_W;
    offs     = val - chroma;
    h120     = hue % 32'd120;
    tri_dist = (h120 >= 32'd60) ? (32'd120 - h120) : h120;
    mid      = (chroma * 64'(tri_dist)) / 64'd60;
    sector   = sector_e'(3'(hue / 32'd60));
    case (sector)
      SEC_RED:     comp = '{chroma, mid, 64'd0};
      SEC_YELLOW:  comp = '{mid, chroma, 64'd0};
      SEC_GREEN:   comp = '{64'd0, chroma, mid};
      SEC_CYAN:    comp = '{64'd0, mid, chroma};
      SEC_BLUE:    comp = '{mid, 64'd0, chroma};
      default:     comp = '{chroma, 64'd0, mid};
    endcase
    res.red   = 8'(((comp[0] + offs) * 64'd255) >> FRAC_BITS);
    res.green = 8'(((comp[1] + offs) * 64'd255) >> FRAC_BITS);
    res.blue  = 8'(((comp[2] + offs) * 64'd255) >> FRAC_BITS);
    return res;
  endfunction

  task automatic note_error(string what, int unsigned want_v, int unsigned got_v);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) begin
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want_v, got_v);
    end
  endtask

  // Offer one request, idling at random first; record its result once it is taken
  task automatic send_request(src_colour_t src, bit known, rgb_t typed);
    rgb_t due;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= src;
    do @(posedge clk_i); while (!s_axis_tready);
    due = known ? typed : rotate_hue(src, sat_q, bri_q);
    colour_due.insert(colour_due.size(), due);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (colour_due.size() != 0) @(negedge clk_i);
  endtask

  task automatic apb_write(reg_idx_e idx, logic [REG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(int'(idx) * 4);
    pwdata  <= APB_DATA_W'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Change the colour registers only with the pipeline empty, then let the write settle
  task automatic program_colour(logic [REG_W-1:0] sat, logic [REG_W-1:0] bri);
    drain_results();
    repeat (NUM_STAGES + 2) @(negedge clk_i);
    apb_write(REG_SATURATION, sat);
    apb_write(REG_BRIGHTNESS, bri);
    sat_q = sat;
    bri_q = bri;
    repeat (4) @(negedge clk_i);
  endtask

  function automatic src_colour_t random_colour();
    src_colour_t src;
    int unsigned pick;
    src.red   = ($urandom_range(9) == 0) ? {8{$urandom_range(1) == 1}} : 8'($urandom);
    src.green = ($urandom_range(9) == 0) ? {8{$urandom_range(1) == 1}} : 8'($urandom);
    src.blue  = ($urandom_range(9) == 0) ? {8{$urandom_range(1) == 1}} : 8'($urandom);
    pick = $urandom_range(9);
    if (pick < 3) begin
      src.time_ms = 32'($urandom_range(7199));
    end else if (pick == 3) begin
      src.time_ms = 32'hFFFFFFFF - 32'($urandom_range(7199));
    end else begin
      src.time_ms = $urandom;
    end
    return src;
  endfunction

  // Receiver: random back-pressure, a long hold-off on request, or none while calm
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (hold_go) begin
        hold_go       = 1'b0;
        hold_left     = HOLD_CYCLES - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Compare each result taken by the receiver with the oldest expected colour
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_rgb = m_axis_tdata;
      if (colour_due.size() == 0) begin
        note_error("unexpected result", 0, got_rgb);
      end else begin
        want_rgb = colour_due.pop_front();
        if (got_rgb.red !== want_rgb.red) note_error("out_red", want_rgb.red, got_rgb.red);
        if (got_rgb.green !== want_rgb.green) begin
          note_error("out_green", want_rgb.green, got_rgb.green);
        end
        if (got_rgb.blue !== want_rgb.blue) note_error("out_blue", want_rgb.blue, got_rgb.blue);
      end
    end
  end

  // Guard the run against a hang
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    src_colour_t      src;
    logic [REG_W-1:0] phase_sat [RAND_PHASES];
    logic [REG_W-1:0] phase_bri [RAND_PHASES];

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Opening rows: reprogram whenever a row asks for another setting
    foreach (opening_rows[i]) begin
      if (opening_rows[i].sat != sat_q || opening_rows[i].bri != bri_q) begin
        program_colour(opening_rows[i].sat, opening_rows[i].bri);
      end
      src = '{opening_rows[i].time_ms, opening_rows[i].blue, opening_rows[i].green,
              opening_rows[i].red};
      send_request(src, opening_rows[i].known, opening_rows[i].want);
    end

    // Random phases, each under its own setting; extremes and reset values among them
    phase_sat = '{SATURATION_RST, 16'hFFFF, 16'd0, 16'($urandom), 16'($urandom),
                  16'hFFFF, 16'($urandom_range(15)), 16'($urandom)};
    phase_bri = '{BRIGHTNESS_RST, 16'hFFFF, 16'hFFFF, 16'($urandom), 16'($urandom),
                  16'd0, 16'($urandom_range(15)), BRIGHTNESS_RST};
    for (int p = 0; p < RAND_PHASES; p++) begin
      program_colour(phase_sat[p], phase_bri[p]);
      calm = (p == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Hold off the receiver so the pipeline fills and stalls the input
        if ((p == 2 || p == 5) && n == 20) hold_go = 1'b1;
        // Stop offering until every outstanding result has come back
        if (p == 2 && n == 60) drain_results();
        send_request(random_colour(), 1'b0, '0);
      end
      calm = 1'b0;
    end

    drain_results();
    repeat (NUM_STAGES * 4) @(posedge clk_i);
    if (err_cnt == 0 && colour_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
